// File: rtl/id3fx_pkg.sv
// id3fx_pkg: shared types, codes and constants of the id3 frame extractor
// used by every module under rtl; depends on nothing

package id3fx_pkg;

	localparam int unsigned HEADER_LEN = 10;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ID_W     = 32;
	localparam int unsigned LIMIT_W  = 28;
	localparam int unsigned WINDOW_W = 24;
	localparam int unsigned SIZE_W   = 32;
	localparam int unsigned HCOUNT_W = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT = 2'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SEARCH = 3'd1,
		PH_SIZE   = 3'd2,
		PH_FLAGS  = 3'd3,
		PH_BODY   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_OK       = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              start_req;
	} in_item_t;

	typedef struct packed {
		logic              char_valid;
		logic [BYTE_W-1:0] out_char;
		status_t           status;
	} result_t;

endpackage

// File: rtl/id3fx_in_stage.sv
// id3fx_in_stage: input register between the slave stream and the parser
// depends on id3fx_pkg

module id3fx_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  id3fx_pkg::in_item_t in_item,
	input  logic                take,
	output logic                item_valid,
	output id3fx_pkg::in_item_t item
);

	logic                valid_s1;
	id3fx_pkg::in_item_t item_s1;

	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/id3fx_parser.sv
// id3fx_parser: parse state and per-byte logic (header skip, id search, size, flags, body)
// depends on id3fx_pkg

module id3fx_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  id3fx_pkg::in_item_t                   item,
	input  logic [id3fx_pkg::ID_W-1:0]            frame_id,
	input  logic [id3fx_pkg::LIMIT_W-1:0]         search_limit,
	output logic                                  emit,
	output id3fx_pkg::result_t                    result
);

	localparam id3fx_pkg::phase_t RESTART_PHASE =
		(id3fx_pkg::HEADER_LEN == 0) ? id3fx_pkg::PH_SEARCH : id3fx_pkg::PH_HEADER;

	id3fx_pkg::phase_t                     phase_q, phase_d, phase_e;
	logic [id3fx_pkg::HCOUNT_W-1:0]        hcount_q, hcount_d, hcount_e;
	logic [id3fx_pkg::WINDOW_W-1:0]        window_q, window_d, window_e;
	logic [1:0]                            fill_q, fill_d, fill_e;
	logic [id3fx_pkg::LIMIT_W-1:0]         tried_q, tried_d, tried_e;
	logic [1:0]                            fcount_q, fcount_d, fcount_e;
	logic [id3fx_pkg::SIZE_W-1:0]          remain_q, remain_d, remain_e;
	logic [id3fx_pkg::ID_W-1:0]            cand;
	logic [id3fx_pkg::LIMIT_W-1:0]         tried_inc;
	logic [1:0]                            fcount_inc;
	logic [id3fx_pkg::SIZE_W-1:0]          remain_dec;
	logic                                  printable;

	// state as seen by this byte, after a possible restart
	always_comb begin
		if (item.start_req) begin
			phase_e  = RESTART_PHASE;
			hcount_e = '0;
			window_e = '0;
			fill_e   = '0;
			tried_e  = '0;
			fcount_e = '0;
			remain_e = '0;
		end else begin
			phase_e  = phase_q;
			hcount_e = hcount_q;
			window_e = window_q;
			fill_e   = fill_q;
			tried_e  = tried_q;
			fcount_e = fcount_q;
			remain_e = remain_q;
		end
	end

	assign cand       = {window_e, item.in_byte};
	assign tried_inc  = tried_e + 1'b1;
	assign fcount_inc = fcount_e + 1'b1;
	assign remain_dec = remain_e - 1'b1;
	assign printable  = (item.in_byte >= id3fx_pkg::PRINT_LO) &&
		(item.in_byte <= id3fx_pkg::PRINT_HI);

	// next state
	always_comb begin
		phase_d  = phase_e;
		hcount_d = hcount_e;
		window_d = window_e;
		fill_d   = fill_e;
		tried_d  = tried_e;
		fcount_d = fcount_e;
		remain_d = remain_e;
		case (phase_e)
			id3fx_pkg::PH_HEADER: begin
				hcount_d = hcount_e + 1'b1;
				if (hcount_d >= id3fx_pkg::HCOUNT_W'(id3fx_pkg::HEADER_LEN)) begin
					phase_d = id3fx_pkg::PH_SEARCH;
				end
			end
			id3fx_pkg::PH_SEARCH: begin
				if (fill_e != 2'd3) begin
					window_d = cand[id3fx_pkg::WINDOW_W-1:0];
					fill_d   = fill_e + 1'b1;
				end else begin
					tried_d = tried_inc;
					if (cand == frame_id) begin
						phase_d  = id3fx_pkg::PH_SIZE;
						fcount_d = '0;
						remain_d = '0;
					end else if (tried_inc >= search_limit) begin
						phase_d = id3fx_pkg::PH_DONE;
					end else begin
						window_d = cand[id3fx_pkg::WINDOW_W-1:0];
					end
				end
			end
			id3fx_pkg::PH_SIZE: begin
				remain_d = {remain_e[id3fx_pkg::SIZE_W-id3fx_pkg::BYTE_W-1:0], item.in_byte};
				fcount_d = fcount_inc;
				if (fcount_inc == 2'd0) begin
					phase_d = id3fx_pkg::PH_FLAGS;
				end
			end
			id3fx_pkg::PH_FLAGS: begin
				fcount_d = fcount_inc;
				if (fcount_inc >= 2'd2) begin
					fcount_d = '0;
					phase_d  = (remain_e == '0) ? id3fx_pkg::PH_DONE : id3fx_pkg::PH_BODY;
				end
			end
			id3fx_pkg::PH_BODY: begin
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					phase_d = id3fx_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// result of this byte
	always_comb begin
		emit              = 1'b0;
		result.char_valid = 1'b0;
		result.out_char   = '0;
		result.status     = id3fx_pkg::ST_BUSY;
		case (phase_e)
			id3fx_pkg::PH_SEARCH: begin
				if (fill_e == 2'd3 && cand != frame_id && tried_inc >= search_limit) begin
					emit          = 1'b1;
					result.status = id3fx_pkg::ST_NOTFOUND;
				end
			end
			id3fx_pkg::PH_FLAGS: begin
				if (fcount_inc >= 2'd2 && remain_e == '0) begin
					emit          = 1'b1;
					result.status = id3fx_pkg::ST_OK;
				end
			end
			id3fx_pkg::PH_BODY: begin
				if (printable) begin
					emit              = 1'b1;
					result.char_valid = 1'b1;
					result.out_char   = item.in_byte;
				end
				if (remain_dec == '0) begin
					emit          = 1'b1;
					result.status = id3fx_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= RESTART_PHASE;
			hcount_q <= '0;
			window_q <= '0;
			fill_q   <= '0;
			tried_q  <= '0;
			fcount_q <= '0;
			remain_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			tried_q  <= tried_d;
			fcount_q <= fcount_d;
			remain_q <= remain_d;
		end
	end

endmodule

// File: rtl/id3fx_out_stage.sv
// id3fx_out_stage: result register driving the master stream
// depends on id3fx_pkg

module id3fx_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  id3fx_pkg::result_t result,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output id3fx_pkg::result_t out_result
);

	logic               valid_s2;
	id3fx_pkg::result_t result_s2;

	assign can_load   = !valid_s2 || out_ready;
	assign out_valid  = valid_s2;
	assign out_result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_s2 <= result;
		end
	end

endmodule

// File: rtl/id3_frame_extractor_unit.sv
// id3_frame_extractor_unit: top level of the id3 frame extractor
// depends on id3fx_pkg, id3fx_in_stage, id3fx_parser, id3fx_out_stage
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata in_byte, tuser start_req
//   m_*      out  m_tvalid/m_tready    tdata out_char, tuser char_valid, status
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte per cycle while no result waits on m_tready; a byte is held in the input register and its
// result, if any, is loaded into the output register as the parser takes the byte
// the parse state updates in a single pass of compare, shift and counter logic
// a stall on m_tready holds the output register, then the input register,
// then s_tready; bytes without a result pass even while the output waits
// reset restarts the parse as at the first byte of a file; cfg_ready is always high

module id3_frame_extractor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] in_byte
	input  logic [0:0]                          s_tuser,   // [0] start_req
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // [7:0] out_char
	output logic [2:0]                          m_tuser,   // [0] char_valid, [2:1] status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [id3fx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data
);

	logic [id3fx_pkg::ID_W-1:0]    frame_id_q;
	logic [id3fx_pkg::LIMIT_W-1:0] search_limit_q;
	id3fx_pkg::in_item_t           in_item;
	id3fx_pkg::in_item_t           item;
	logic                          item_valid;
	logic                          advance;
	logic                          emit;
	logic                          can_load;
	id3fx_pkg::result_t            result;
	id3fx_pkg::result_t            out_result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q     <= '0;
			search_limit_q <= id3fx_pkg::LIMIT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				id3fx_pkg::REG_FRAME_ID:     frame_id_q <= cfg_data;
				id3fx_pkg::REG_SEARCH_LIMIT: search_limit_q <= cfg_data[id3fx_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_item.in_byte   = s_tdata;
	assign in_item.start_req = s_tuser[0];

	assign advance = item_valid && (!emit || can_load);

	id3fx_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.take       (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	id3fx_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item),
		.frame_id     (frame_id_q),
		.search_limit (search_limit_q),
		.emit         (emit),
		.result       (result)
	);

	id3fx_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && emit),
		.result     (result),
		.can_load   (can_load),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = out_result.out_char;
	assign m_tuser = {out_result.status, out_result.char_valid};

endmodule

// File: rtl/id3fx_checker.sv
// id3fx_checker: port-level assertions for id3_frame_extractor_unit, with bind
// depends on id3fx_pkg and id3_frame_extractor_unit

module id3fx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser
);

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		(m_tdata >= id3fx_pkg::PRINT_LO && m_tdata <= id3fx_pkg::PRINT_HI))
		else $error("character outside printable range");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
		else $error("out_char nonzero without char_valid");

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser[2:1] != 2'd3) &&
		(m_tuser[0] || m_tuser[2:1] != id3fx_pkg::ST_BUSY)))
		else $error("result with no character and busy status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled transfer changed");

endmodule

bind id3_frame_extractor_unit id3fx_checker u_id3fx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
